### rtl/tdpg_pkg.sv
`timescale 1ns / 1ps

package tdpg_pkg;

  localparam int DEFAULT_MAX_PRIMES = 1024;
  localparam int DEFAULT_VALUE_BITS = 24;

  localparam int LIMIT_W  = 11;
  localparam int INDEX_W  = 11;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);
  localparam int                 FIRST_PRIME = 2;

  // register index, taken from paddr[2]
  localparam logic REG_PRIME_COUNT_LIMIT = 1'b0;

  typedef struct packed {
    logic done;   // one-cycle pulse at the end of a remainder run
    logic zero;   // remainder is zero, valid with done
  } rem_status_t;

endpackage

### rtl/tdpg_rem_unit.sv
`timescale 1ns / 1ps

// Restoring remainder unit, one dividend bit per cycle.
module tdpg_rem_unit #(
  parameter int VALUE_BITS = tdpg_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_BITS-1:0]  dividend_i,
  input  logic [VALUE_BITS-1:0]  divisor_i,
  output tdpg_pkg::rem_status_t  status_o
);
  import tdpg_pkg::*;

  localparam int CNTW = $clog2(VALUE_BITS);

  logic                  busy_q;
  logic                  done_q;
  logic [CNTW-1:0]       cnt_q;
  logic [VALUE_BITS:0]   rem_q;
  logic [VALUE_BITS-1:0] dvd_q;
  logic [VALUE_BITS-1:0] dsr_q;

  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS:0]   rem_d;

  always_comb begin
    shifted = {rem_q[VALUE_BITS-1:0], dvd_q[VALUE_BITS-1]};
    if (shifted >= {1'b0, dsr_q}) begin
      rem_d = shifted - {1'b0, dsr_q};
    end else begin
      rem_d = shifted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(VALUE_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[VALUE_BITS-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign status_o.done = done_q;
  assign status_o.zero = (rem_q == '0);

endmodule

### rtl/tdpg_cfg_regs.sv
`timescale 1ns / 1ps

module tdpg_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tdpg_pkg::APB_AW-1:0]    paddr,
  input  logic [tdpg_pkg::APB_DW-1:0]    pwdata,
  output logic [tdpg_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  output logic [tdpg_pkg::LIMIT_W-1:0]   limit_o
);
  import tdpg_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  logic               wr_limit;

  // byte lanes in paddr[1:0] are ignored
  assign wr_limit = psel && penable && pwrite && (paddr[2] == REG_PRIME_COUNT_LIMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (wr_limit) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PRIME_COUNT_LIMIT: prdata = APB_DW'(limit_q);
      default:               prdata = '0;
    endcase
  end

  assign pready  = 1'b1;
  assign limit_o = limit_q;

endmodule

### rtl/trial_division_prime_generator.sv
`timescale 1ns / 1ps

// Prime generator by trial division. Pulse start while busy is low; restart
// clears the table and begins again at 2. Exactly one result follows each
// request, on the result ports for a single cycle marked by result_valid_o,
// and it cannot be held off, so it must be captured when it appears. busy
// stays high from the accepting edge until that result cycle. A request that
// hits the count limit, the table capacity or the end of the value range
// answers done_res_o with value and index zero. Otherwise each
// candidate is tried in order against the stored primes p with p*p <= candidate,
// stopping at the first that divides it: the single bit-serial remainder unit is run
// once per such prime, fed by a registered read of the prime table.
module trial_division_prime_generator #(
  parameter int MAX_PRIMES = tdpg_pkg::DEFAULT_MAX_PRIMES,
  parameter int VALUE_BITS = tdpg_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          restart_i,
  output logic                          result_valid_o,
  output logic [VALUE_BITS-1:0]         prime_value_o,
  output logic [tdpg_pkg::INDEX_W-1:0]  prime_index_o,
  output logic                          done_res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tdpg_pkg::APB_AW-1:0]   paddr,
  input  logic [tdpg_pkg::APB_DW-1:0]   pwdata,
  output logic [tdpg_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import tdpg_pkg::*;

  localparam int CW   = $clog2(MAX_PRIMES + 1);
  localparam int AW   = $clog2(MAX_PRIMES);
  localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int VB   = VALUE_BITS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_NEXT  = 7'b0000100,
    S_READ  = 7'b0001000,
    S_SQ    = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_FOUND = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [VB:0]          cand_q, cand_d;   // one extra bit: may sit past the value range
  logic [VB-1:0]        table_q [MAX_PRIMES];
  logic [VB-1:0]        rdata_q;
  logic [2*VB-1:0]      sq_q;

  logic                 res_valid_q, res_valid_d;
  logic [VB-1:0]        res_value_q, res_value_d;
  logic [INDEX_W-1:0]   res_index_q, res_index_d;
  logic                 res_done_q, res_done_d;

  logic [LIMIT_W-1:0]   limit;
  logic                 at_limit;
  logic                 accept;
  logic                 tbl_we;
  logic                 rem_start;
  rem_status_t          rem_status;

  tdpg_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  tdpg_rem_unit #(
    .VALUE_BITS (VB)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (cand_q[VB-1:0]),
    .divisor_i  (rdata_q),
    .status_o   (rem_status)
  );

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  // count >= min(limit, capacity)
  assign at_limit = (CMPW'(count_q) >= CMPW'(limit)) ||
                    (CMPW'(count_q) >= CMPW'(MAX_PRIMES));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    cand_d      = cand_q;
    res_valid_d = 1'b0;
    res_value_d = res_value_q;
    res_index_d = res_index_q;
    res_done_d  = res_done_q;
    tbl_we      = 1'b0;
    rem_start   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (restart_i) begin
            count_d = '0;
            cand_d  = (VB+1)'(FIRST_PRIME);
          end
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (at_limit || cand_q[VB]) begin
          res_valid_d = 1'b1;
          res_value_d = '0;
          res_index_d = '0;
          res_done_d  = 1'b1;
          state_d     = S_IDLE;
        end else begin
          idx_d   = '0;
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (idx_q == count_q) begin
          state_d = S_FOUND;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_SQ;
      end
      S_SQ: begin
        // no stored prime beyond sqrt(candidate) can be its smallest factor
        if (sq_q > {{(VB-1){1'b0}}, cand_q}) begin
          state_d = S_FOUND;
        end else begin
          rem_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_status.done) begin
          if (rem_status.zero) begin
            cand_d  = cand_q + 1'b1;
            state_d = S_CHECK;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_NEXT;
          end
        end
      end
      S_FOUND: begin
        tbl_we      = 1'b1;
        count_d     = count_q + 1'b1;
        cand_d      = cand_q + 1'b1;
        res_valid_d = 1'b1;
        res_value_d = cand_q[VB-1:0];
        res_index_d = INDEX_W'(count_q + 1'b1);
        res_done_d  = 1'b0;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      cand_q      <= (VB+1)'(FIRST_PRIME);
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      cand_q      <= cand_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_value_q <= res_value_d;
    res_index_q <= res_index_d;
    res_done_q  <= res_done_d;
    sq_q        <= {{VB{1'b0}}, rdata_q} * {{VB{1'b0}}, rdata_q};
  end

  // prime table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      table_q[count_q[AW-1:0]] <= cand_q[VB-1:0];
    end
    rdata_q <= table_q[idx_q[AW-1:0]];
  end

  assign result_valid_o = res_valid_q;
  assign prime_value_o  = res_value_q;
  assign prime_index_o  = res_index_q;
  assign done_res_o     = res_done_q;

`ifndef SYNTHESIS
  a_result_single_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  a_done_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && done_res_o) |-> (prime_value_o == '0 && prime_index_o == '0))
    else $error("done result carries a nonzero prime or index");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(count_q) <= CMPW'(MAX_PRIMES))
    else $error("stored prime count exceeds table capacity");

  a_prime_bumps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FOUND) |=> (result_valid_o && !done_res_o &&
                              count_q == $past(count_q) + 1'b1))
    else $error("found prime not delivered with count update");
`endif

endmodule

### tb/prime_result_checker.sv
`timescale 1ns / 1ps

module prime_result_checker #(
  parameter int MAX_PRIMES = tdpg_pkg::DEFAULT_MAX_PRIMES,
  parameter int VALUE_BITS = tdpg_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic                          restart_i,
  input  logic                          result_valid_i,
  input  logic [VALUE_BITS-1:0]         prime_value_i,
  input  logic [tdpg_pkg::INDEX_W-1:0]  prime_index_i,
  input  logic                          done_res_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [tdpg_pkg::APB_AW-1:0]   paddr_i,
  input  logic [tdpg_pkg::APB_DW-1:0]   pwdata_i,
  input  logic [tdpg_pkg::APB_DW-1:0]   prdata_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            primes_checked_o,
  output int                            done_checked_o
);

  import tdpg_pkg::*;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [INDEX_W-1:0]    index;
    logic                  done;
  } prime_result_t;

  localparam longint unsigned VALUE_TOP = (64'd1 << VALUE_BITS) - 1;

  logic [VALUE_BITS-1:0] found_primes [MAX_PRIMES];
  int unsigned           found_count;
  longint unsigned       next_candidate;
  logic [LIMIT_W-1:0]    count_limit;

  prime_result_t expected_primes [$];
  prime_result_t oldest;

  initial begin
    fail_count_o     = 0;
    pending_o        = 0;
    primes_checked_o = 0;
    done_checked_o   = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] prime check: %s", $time, what);
    fail_count_o++;
  endtask

  // Next prime by trial division against the stored table; done when the
  // effective limit (capped at table capacity) or the value range runs out.
  function automatic prime_result_t find_next_prime(input logic restart);
    prime_result_t r;
    int unsigned   cap;
    bit            divides;
    r = '{value: '0, index: '0, done: 1'b1};
    if (restart) begin
      found_count    = 0;
      next_candidate = FIRST_PRIME;
    end
    cap = (count_limit > MAX_PRIMES) ? MAX_PRIMES : count_limit;
    if (found_count >= cap) return r;
    divides = 1'b1;
    while (divides && next_candidate <= VALUE_TOP) begin
      divides = 1'b0;
      for (int i = 0; i < found_count; i++) begin
        if (found_primes[i] != 0 && next_candidate % found_primes[i] == 0) begin
          divides = 1'b1;
          break;
        end
      end
      if (divides) next_candidate++;
    end
    if (next_candidate > VALUE_TOP) return r;
    found_primes[found_count] = next_candidate[VALUE_BITS-1:0];
    found_count++;
    r.value = next_candidate[VALUE_BITS-1:0];
    r.index = INDEX_W'(found_count);
    r.done  = 1'b0;
    next_candidate++;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_count    = 0;
      next_candidate = FIRST_PRIME;
      count_limit    = LIMIT_RESET;
      expected_primes.delete();
      pending_o      = 0;
    end else begin
      if (result_valid_i) begin
        if (expected_primes.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: value %0d index %0d done %0b",
                                    prime_value_i, prime_index_i, done_res_i));
        end else begin
          oldest = expected_primes.pop_front();
          if (prime_value_i !== oldest.value)
            report_mismatch($sformatf("prime_value %0d, want %0d", prime_value_i, oldest.value));
          if (prime_index_i !== oldest.index)
            report_mismatch($sformatf("prime_index %0d, want %0d", prime_index_i, oldest.index));
          if (done_res_i !== oldest.done)
            report_mismatch($sformatf("done_res %0b, want %0b", done_res_i, oldest.done));
          if (oldest.done) done_checked_o++;
          else primes_checked_o++;
        end
      end
      if (start_i && !busy_i)
        expected_primes.push_back(find_next_prime(restart_i));
      if (psel_i && penable_i && pready_i && paddr_i[2] == REG_PRIME_COUNT_LIMIT) begin
        if (pwrite_i)
          count_limit = pwdata_i[LIMIT_W-1:0];
        else if (prdata_i[LIMIT_W-1:0] !== count_limit)
          report_mismatch($sformatf("limit readback %0d, want %0d",
                                    prdata_i[LIMIT_W-1:0], count_limit));
      end
      pending_o = expected_primes.size();
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import tdpg_pkg::*;

  localparam int VB = DEFAULT_VALUE_BITS;

  localparam logic [APB_AW-1:0] ADDR_LIMIT    = {REG_PRIME_COUNT_LIMIT, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNMAPPED = {~REG_PRIME_COUNT_LIMIT, 2'b00};

  localparam logic [LIMIT_W-1:0] LIMIT_ALL_ONES = '1;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                start      = 1'b0;
  logic                busy;
  logic                restart_i  = 1'b0;
  logic                result_valid_o;
  logic [VB-1:0]       prime_value_o;
  logic [INDEX_W-1:0]  prime_index_o;
  logic                done_res_o;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [APB_AW-1:0]   paddr      = '0;
  logic [APB_DW-1:0]   pwdata     = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int fail_count;
  int pending;
  int primes_checked;
  int done_checked;

  int requests_sent = 0;
  int restarts_sent = 0;
  int limit_writes  = 0;

  int idle_by_phase [8] = '{0, 87, 20, 0, 87, 20, 0, 87};

  trial_division_prime_generator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .restart_i      (restart_i),
    .result_valid_o (result_valid_o),
    .prime_value_o  (prime_value_o),
    .prime_index_o  (prime_index_o),
    .done_res_o     (done_res_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  prime_result_checker #(
    .MAX_PRIMES (DEFAULT_MAX_PRIMES),
    .VALUE_BITS (VB)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .restart_i        (restart_i),
    .result_valid_i   (result_valid_o),
    .prime_value_i    (prime_value_o),
    .prime_index_i    (prime_index_o),
    .done_res_i       (done_res_o),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .prdata_i         (prdata),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .primes_checked_o (primes_checked),
    .done_checked_o   (done_checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Random idle gap (restart toggling as noise), then hold start until the
  // transfer goes through. start is left high on return.
  task automatic send_request(input logic restart, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start     <= 1'b0;
      restart_i <= $urandom_range(1);
      @(posedge clk_i);
    end
    start     <= 1'b1;
    restart_i <= restart;
    do @(posedge clk_i); while (busy);
    requests_sent++;
    if (restart) restarts_sent++;
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [APB_AW-1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Limit write with random upper bits, then read it back.
  task automatic set_limit(input logic [LIMIT_W-1:0] lim);
    logic [APB_DW-1:0] data;
    data = $urandom;
    data[LIMIT_W-1:0] = lim;
    apb_write(ADDR_LIMIT, data);
    apb_read(ADDR_LIMIT);
    limit_writes++;
  endtask

  // Block is idle once every request has answered and busy has dropped.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(6))
      0:       return '0;
      1:       return LIMIT_W'(1);
      2:       return LIMIT_ALL_ONES;
      3:       return LIMIT_RESET;
      default: return LIMIT_W'($urandom_range(2, 120));
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value of the limit, then first primes straight out of reset
    apb_read(ADDR_LIMIT);
    repeat (4) send_request(1'b0, 0);
    send_request(1'b1, 0);
    send_request(1'b0, 0);

    // limit of zero: done even on a restart
    settle();
    set_limit('0);
    send_request(1'b0, 0);
    send_request(1'b1, 0);

    // limit of one
    settle();
    set_limit(LIMIT_W'(1));
    send_request(1'b1, 0);
    send_request(1'b0, 0);
    send_request(1'b0, 0);

    // unmapped register: write must not touch the limit
    settle();
    apb_write(ADDR_UNMAPPED, '0);
    apb_read(ADDR_LIMIT);
    send_request(1'b1, 0);
    send_request(1'b0, 0);

    // limit above capacity: capped at the table size, so primes keep coming
    settle();
    set_limit(LIMIT_ALL_ONES);
    send_request(1'b1, 0);
    repeat (40) send_request(1'b0, 0);

    // limit back at its reset value
    settle();
    set_limit(LIMIT_RESET);
    send_request(1'b0, 0);
    send_request(1'b1, 0);

    // random runs: mostly plain next requests, an occasional restart, under varied limits
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      set_limit(pick_limit());
      if (ph == 3) apb_write(ADDR_UNMAPPED, $urandom);
      for (int n = 0; n < 30; n++)
        send_request($urandom_range(11) == 0, idle_by_phase[ph]);
    end

    settle();
    $display("Covered %0d requests (%0d with restart) under %0d limit settings.",
             requests_sent, restarts_sent, limit_writes);
    $display("Checked %0d primes and %0d done answers.", primes_checked, done_checked);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // far beyond the longest request mix this run can produce
  initial begin
    #200_000_000;
    $display("Timeout waiting on the prime generator");
    $display("Some tests failed");
    $finish;
  end

endmodule
